// ===== rtl/core/brhq_pkg.sv =====
// ----------------------------------------------------------------------------
// brhq_pkg
// Shared constants, codes and types of the block request hazard queue.
// ----------------------------------------------------------------------------
package brhq_pkg;

	localparam int ENTRIES = 64;
	localparam int IW      = $clog2(ENTRIES);
	localparam int CW      = $clog2(ENTRIES + 1);
	localparam int CMPW    = (CW > 6) ? CW : 6;
	localparam int ENDW    = 49;

	localparam logic [ENDW-1:0] END_MARKER = {ENDW{1'b1}};

	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DISP = 2'd1;
	localparam logic [1:0] MODE_CMPL = 2'd2;
	localparam logic [1:0] MODE_CXL  = 2'd3;

	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_FLUSH  = 2'd2;
	localparam logic [1:0] KIND_DELETE = 2'd3;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_NONE     = 3'd2;
	localparam logic [2:0] STAT_NOTFOUND = 3'd3;
	localparam logic [2:0] STAT_BUSY     = 3'd4;
	localparam logic [2:0] STAT_ROFS     = 3'd5;
	localparam logic [2:0] STAT_NOTSUP   = 3'd6;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0,
		ST_BLK  = 2'd1,
		ST_PEND = 2'd2,
		ST_BUSY = 2'd3
	} estate_t;

	typedef struct packed {
		logic [15:0]     tag;
		logic [1:0]      kind;
		logic [47:0]     start;
		logic [ENDW-1:0] end_off;
	} ent_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  op_kind;
		logic [15:0] request_tag;
		logic [47:0] start_offset;
		logic [23:0] total_length;
		logic [5:0]  entry_index;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [15:0] tag_out;
		logic [1:0]  kind_out;
		logic        was_blocked;
	} res_t;

endpackage

// ===== rtl/core/brhq_if.sv =====
// ----------------------------------------------------------------------------
// brhq_req_if / brhq_rsp_if
// Valid/ready channels carrying request beats and result beats.
// ----------------------------------------------------------------------------
interface brhq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [1:0]  op_kind;
	logic [15:0] request_tag;
	logic [47:0] start_offset;
	logic [23:0] total_length;
	logic [5:0]  entry_index;

	modport source (output valid, mode, op_kind, request_tag, start_offset, total_length,
		entry_index, input ready);
	modport sink (input valid, mode, op_kind, request_tag, start_offset, total_length,
		entry_index, output ready);
endinterface

interface brhq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  slot;
	logic [15:0] tag_out;
	logic [1:0]  kind_out;
	logic        was_blocked;

	modport source (output valid, status, slot, tag_out, kind_out, was_blocked, input ready);
	modport sink (input valid, status, slot, tag_out, kind_out, was_blocked, output ready);
endinterface

// ===== rtl/core/brhq_ram.sv =====
// ----------------------------------------------------------------------------
// brhq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module brhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/brhq_seq.sv =====
// ----------------------------------------------------------------------------
// brhq_seq
// Sequencer: entry state, free ring, pending list and a shared compare unit
// that scans entries one per cycle.
// ----------------------------------------------------------------------------
module brhq_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  brhq_pkg::item_t item,
	input  logic           read_only,
	output logic           res_valid,
	input  logic           res_take,
	output brhq_pkg::res_t  res
);
	import brhq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ENQ_RING, S_SCAN, S_ENQ_WR, S_RT_END, S_RT_CAP,
		S_SH_RD, S_SH_WR, S_RT_FREE, S_DONE
	} fsm_t;

	typedef enum logic [2:0] {
		SC_HAZ, SC_DISP, SC_FIND, SC_UNBLK, SC_CXL, SC_BUSY
	} scan_t;

	fsm_t            fsm_q;
	scan_t           sc_q;
	item_t           item_q;
	estate_t         ent_st_q [ENTRIES];
	logic            ring_wr_q [ENTRIES];
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   fcnt_q;
	logic [CW-1:0]   pcnt_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   pos_q;
	logic [ENDW-1:0] end_q;
	logic            hazard_q;
	logic [CW-1:0]   cnt_q;
	logic            v1_q;
	logic [IW-1:0]   pos1_q;
	logic            v2_q;
	logic [IW-1:0]   pos2_q;
	logic [IW-1:0]   e2_q;
	res_t            res_q;

	logic            ent_we;
	ent_t            ent_wdata;
	logic [IW-1:0]   ent_raddr;
	ent_t            ent_rdata;
	logic            ord_we;
	logic [IW-1:0]   ord_waddr;
	logic [IW-1:0]   ord_wdata;
	logic [IW-1:0]   ord_raddr;
	logic [IW-1:0]   ord_rdata;
	logic            ring_we;
	logic [IW-1:0]   ring_waddr;
	logic [IW-1:0]   ring_rdata;

	logic            direct;
	logic [CW-1:0]   lim;
	logic [IW-1:0]   e1;
	logic [ENDW-1:0] cmp_a;
	logic [ENDW-1:0] cmp_b;
	logic            eq;
	estate_t         st2;
	logic            hit;
	logic            haz_hit;
	logic            unb_hit;
	logic            issue;
	logic            scan_end;
	logic [CW-1:0]   pos_nx;
	logic [CW:0]     ring_sum;
	logic [CW:0]     ring_wrap;
	logic            bad_idx;
	logic [2:0]      disp_stat;

	brhq_ram #(.WIDTH($bits(ent_t)), .DEPTH(ENTRIES)) u_ent (
		.clk  (clk),
		.we   (ent_we),
		.waddr(idx_q),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	brhq_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_ord (
		.clk  (clk),
		.we   (ord_we),
		.waddr(ord_waddr),
		.wdata(ord_wdata),
		.raddr(ord_raddr),
		.rdata(ord_rdata)
	);

	brhq_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(idx_q),
		.raddr(head_q),
		.rdata(ring_rdata)
	);

	always_comb begin
		direct = (sc_q == SC_HAZ) || (sc_q == SC_BUSY);
		lim    = direct ? CW'(ENTRIES) : pcnt_q;
		e1     = direct ? pos1_q : ord_rdata;

		ent_raddr = (fsm_q == S_SCAN) ? e1 : idx_q;
		ent_we    = (fsm_q == S_ENQ_WR);
		ent_wdata.tag     = item_q.request_tag;
		ent_wdata.kind    = item_q.op_kind;
		ent_wdata.start   = item_q.start_offset;
		ent_wdata.end_off = (item_q.op_kind == KIND_FLUSH) ? END_MARKER :
			({1'b0, item_q.start_offset} + ENDW'(item_q.total_length));

		pos_nx    = CW'(CW'(pos_q) + 1'b1);
		ord_we    = (fsm_q == S_SH_WR) || (fsm_q == S_ENQ_WR);
		ord_waddr = (fsm_q == S_SH_WR) ? pos_q : IW'(pcnt_q);
		ord_wdata = (fsm_q == S_SH_WR) ? ord_rdata : idx_q;
		ord_raddr = (fsm_q == S_SH_RD) ? IW'(pos_nx) : IW'(cnt_q);

		ring_sum   = (CW+1)'(head_q) + (CW+1)'(fcnt_q);
		ring_wrap  = (ring_sum >= (CW+1)'(ENTRIES)) ? (CW+1)'(ring_sum - (CW+1)'(ENTRIES))
			: ring_sum;
		ring_waddr = IW'(ring_wrap);
		ring_we    = (fsm_q == S_RT_FREE) && (fcnt_q < CW'(ENTRIES));

		case (sc_q)
			SC_HAZ: begin
				cmp_a = ent_rdata.end_off;
				cmp_b = {1'b0, item_q.start_offset};
			end
			SC_UNBLK: begin
				cmp_a = {1'b0, ent_rdata.start};
				cmp_b = end_q;
			end
			SC_CXL, SC_BUSY: begin
				cmp_a = ENDW'(ent_rdata.tag);
				cmp_b = ENDW'(item_q.request_tag);
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
		eq  = (cmp_a == cmp_b);
		st2 = ent_st_q[e2_q];

		case (sc_q)
			SC_DISP: hit = v2_q && (st2 == ST_PEND);
			SC_FIND: hit = v2_q && (e2_q == idx_q);
			SC_CXL:  hit = v2_q && eq;
			SC_BUSY: hit = v2_q && eq && (st2 == ST_BUSY);
			default: hit = 1'b0;
		endcase
		haz_hit  = v2_q && (sc_q == SC_HAZ) && (st2 != ST_FREE) && eq;
		unb_hit  = v2_q && (sc_q == SC_UNBLK) && eq;
		issue    = (cnt_q < lim) && !hit;
		scan_end = (cnt_q >= lim) && !v1_q && !v2_q;

		bad_idx = (CMPW'(item.entry_index) >= CMPW'(ENTRIES)) ||
			(ent_st_q[IW'(item.entry_index)] == ST_FREE);

		if (ent_rdata.kind == KIND_WRITE && read_only) begin
			disp_stat = STAT_ROFS;
		end else if (ent_rdata.kind == KIND_DELETE) begin
			disp_stat = STAT_NOTSUP;
		end else begin
			disp_stat = STAT_OK;
		end

		item_ready = (fsm_q == S_IDLE);
		res_valid  = (fsm_q == S_DONE);
		res        = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= S_IDLE;
			sc_q     <= SC_HAZ;
			head_q   <= '0;
			fcnt_q   <= CW'(ENTRIES);
			pcnt_q   <= '0;
			cnt_q    <= '0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			hazard_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				ent_st_q[i]  <= ST_FREE;
				ring_wr_q[i] <= 1'b0;
			end
		end else begin
			unique case (fsm_q)
				S_IDLE: begin
					if (item_valid) begin
						item_q <= item;
						res_q  <= '0;
						cnt_q  <= '0;
						v1_q   <= 1'b0;
						v2_q   <= 1'b0;
						unique case (item.mode)
							MODE_ENQ: begin
								hazard_q <= 1'b0;
								if (fcnt_q == '0) begin
									res_q.status <= STAT_FULL;
									fsm_q        <= S_DONE;
								end else begin
									fsm_q <= S_ENQ_RING;
								end
							end
							MODE_DISP: begin
								sc_q  <= SC_DISP;
								fsm_q <= S_SCAN;
							end
							MODE_CMPL: begin
								if (bad_idx) begin
									res_q.status <= STAT_NOTFOUND;
									res_q.slot   <= item.entry_index;
									fsm_q        <= S_DONE;
								end else begin
									idx_q <= IW'(item.entry_index);
									fsm_q <= S_RT_END;
								end
							end
							default: begin
								sc_q  <= SC_CXL;
								fsm_q <= S_SCAN;
							end
						endcase
					end
				end
				S_ENQ_RING: begin
					idx_q  <= ring_wr_q[head_q] ? ring_rdata
						: IW'(CW'(ENTRIES - 1) - CW'(head_q));
					head_q <= (head_q == IW'(ENTRIES - 1)) ? '0 : IW'(head_q + 1'b1);
					fcnt_q <= CW'(fcnt_q - 1'b1);
					sc_q   <= SC_HAZ;
					fsm_q  <= S_SCAN;
				end
				S_SCAN: begin
					v1_q   <= issue;
					pos1_q <= IW'(cnt_q);
					if (issue) begin
						cnt_q <= CW'(cnt_q + 1'b1);
					end
					v2_q   <= v1_q && !hit;
					pos2_q <= pos1_q;
					e2_q   <= e1;
					if (haz_hit) begin
						hazard_q <= 1'b1;
					end
					if (unb_hit) begin
						ent_st_q[e2_q] <= ST_PEND;
					end
					if (hit) begin
						v1_q <= 1'b0;
						v2_q <= 1'b0;
						unique case (sc_q)
							SC_DISP: begin
								ent_st_q[e2_q] <= ST_BUSY;
								pos_q          <= pos2_q;
								res_q.status   <= disp_stat;
								res_q.slot     <= 6'(e2_q);
								res_q.tag_out  <= ent_rdata.tag;
								res_q.kind_out <= ent_rdata.kind;
								fsm_q          <= S_SH_RD;
							end
							SC_FIND: begin
								pos_q <= pos2_q;
								fsm_q <= S_SH_RD;
							end
							SC_CXL: begin
								idx_q <= e2_q;
								fsm_q <= S_RT_END;
							end
							default: begin
								res_q.status <= STAT_BUSY;
								fsm_q        <= S_DONE;
							end
						endcase
					end else if (scan_end) begin
						cnt_q <= '0;
						unique case (sc_q)
							SC_HAZ:   fsm_q <= S_ENQ_WR;
							SC_DISP: begin
								res_q.status <= STAT_NONE;
								fsm_q        <= S_DONE;
							end
							SC_FIND:  sc_q <= SC_UNBLK;
							SC_UNBLK: fsm_q <= S_RT_FREE;
							SC_CXL:   sc_q <= SC_BUSY;
							default: begin
								res_q.status <= STAT_NOTFOUND;
								fsm_q        <= S_DONE;
							end
						endcase
					end
				end
				S_ENQ_WR: begin
					ent_st_q[idx_q]   <= hazard_q ? ST_BLK : ST_PEND;
					pcnt_q            <= CW'(pcnt_q + 1'b1);
					res_q.status      <= STAT_OK;
					res_q.slot        <= 6'(idx_q);
					res_q.was_blocked <= hazard_q;
					fsm_q             <= S_DONE;
				end
				S_RT_END: begin
					fsm_q <= S_RT_CAP;
				end
				S_RT_CAP: begin
					end_q <= ent_rdata.end_off;
					cnt_q <= '0;
					v1_q  <= 1'b0;
					v2_q  <= 1'b0;
					if (ent_st_q[idx_q] == ST_BLK || ent_st_q[idx_q] == ST_PEND) begin
						sc_q <= SC_FIND;
					end else begin
						sc_q <= SC_UNBLK;
					end
					fsm_q <= S_SCAN;
				end
				S_SH_RD: begin
					if (pos_nx < pcnt_q) begin
						fsm_q <= S_SH_WR;
					end else begin
						pcnt_q <= CW'(pcnt_q - 1'b1);
						if (sc_q == SC_DISP) begin
							fsm_q <= S_DONE;
						end else begin
							sc_q  <= SC_UNBLK;
							cnt_q <= '0;
							v1_q  <= 1'b0;
							v2_q  <= 1'b0;
							fsm_q <= S_SCAN;
						end
					end
				end
				S_SH_WR: begin
					pos_q <= IW'(pos_nx);
					fsm_q <= S_SH_RD;
				end
				S_RT_FREE: begin
					ent_st_q[idx_q] <= ST_FREE;
					if (ring_we) begin
						ring_wr_q[ring_waddr] <= 1'b1;
						fcnt_q                <= CW'(fcnt_q + 1'b1);
					end
					res_q.status <= STAT_OK;
					res_q.slot   <= 6'(idx_q);
					fsm_q        <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						fsm_q <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/block_request_hazard_queue.sv =====
// ----------------------------------------------------------------------------
// block_request_hazard_queue
// Request entry pool with offset hazard blocking, in-order dispatch,
// completion and cancel by tag.
// ----------------------------------------------------------------------------
// One request beat is taken at a time; the next is taken once its result has
// moved into the output register. Enqueue scans all ENTRIES for an offset
// hazard; dispatch, complete and cancel walk the pending list. Each scan takes
// one entry per cycle through a single compare unit reading the entry RAM,
// behind a registered read pipeline (v1, v2); dispatch then closes up the
// pending list. Complete and cancel read the pending list and the entry RAM
// in turn; a cancel that finds no queued match adds a scan of all ENTRIES.
// A full enqueue and a bad complete index skip the scans.
// ----------------------------------------------------------------------------
module block_request_hazard_queue (
	input  logic        clk,
	input  logic        arst_n,
	brhq_req_if.sink    req,
	brhq_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import brhq_pkg::*;

	logic  ro_q;
	logic  out_v_q;
	res_t  out_q;
	item_t item;
	res_t  res;
	logic  res_valid;
	logic  res_take;

	assign item.mode         = req.mode;
	assign item.op_kind      = req.op_kind;
	assign item.request_tag  = req.request_tag;
	assign item.start_offset = req.start_offset;
	assign item.total_length = req.total_length;
	assign item.entry_index  = req.entry_index;

	assign res_take = !out_v_q || rsp.ready;

	brhq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(req.valid),
		.item_ready(req.ready),
		.item      (item),
		.read_only (ro_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ro_q <= cfg_wdata;
			end
			if (res_take) begin
				out_v_q <= res_valid;
				if (res_valid) begin
					out_q <= res;
				end
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_q.status;
	assign rsp.slot        = out_q.slot;
	assign rsp.tag_out     = out_q.tag_out;
	assign rsp.kind_out    = out_q.kind_out;
	assign rsp.was_blocked = out_q.was_blocked;

endmodule
